>>> sv/syn_ck_pkg.sv
// Package with the hash constants, pipeline types and ARX round functions.
`default_nettype none

package syn_ck_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_KEY_LOW      = 2'd0;
    localparam logic [1:0] REG_KEY_HIGH     = 2'd1;
    localparam logic [1:0] REG_PERIOD_SHIFT = 2'd2;
    localparam logic [1:0] REG_MAX_AGE      = 2'd3;

    localparam logic [31:0] KEY_LOW_RST      = 32'h3332_3130;
    localparam logic [31:0] KEY_HIGH_RST     = 32'h4241_3938;
    localparam logic [4:0]  PERIOD_SHIFT_RST = 5'd12;
    localparam logic [7:0]  MAX_AGE_RST      = 8'd3;

    localparam logic [31:0] IV0       = 32'h7073_6575;
    localparam logic [31:0] IV1       = 32'h6e64_6f6d;
    localparam logic [31:0] IV2       = 32'h6e65_7261;
    localparam logic [31:0] IV3       = 32'h7974_6573;
    localparam logic [31:0] FINAL_XOR = 32'h0000_00ff;

    // 4 message words x 2 rounds + 4 final rounds, two half rounds each
    localparam int NUM_HALF = 24;
    localparam int IDX_FIN  = NUM_HALF + 1;
    localparam int IDX_OUT  = NUM_HALF + 2;

    typedef logic [3:0][31:0] t_words;

    typedef struct packed {
        t_words      v;
        t_words      m;
        logic [31:0] part;
        logic        bypass;
    } t_hstage;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // first half of a round: two adds, rotate, mix
    function automatic t_words half_a(input t_words s);
        t_words r;
        r[0] = s[0] + s[1];
        r[2] = s[2] + s[3];
        r[1] = rotl(s[1], 5) ^ r[0];
        r[3] = rotl(s[3], 8) ^ r[2];
        r[0] = rotl(r[0], 16);
        return r;
    endfunction

    // second half of a round
    function automatic t_words half_b(input t_words s);
        t_words r;
        r[2] = s[2] + s[1];
        r[0] = s[0] + s[3];
        r[1] = rotl(s[1], 13) ^ r[2];
        r[3] = rotl(s[3], 7) ^ r[0];
        r[2] = rotl(r[2], 16);
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/syn_cookie_halfsiphash_check.sv
// Stages 1..24 each hold one ARX half round (two adds).
// Throughput: one packet per cycle while the master side takes results.
// Backpressure ripples stage by stage, so bubbles are squeezed out during a stall.
// Reset (synchronous, active low) clears all valid bits and loads the default
// key, period shift and max age; no clearing pass, the block is ready at once.
`default_nettype none

module syn_cookie_halfsiphash_check
    import syn_ck_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // configuration write port
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_addr,
    input  wire logic [31:0]  i_cfg_data,
    // packet slave side
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // tdata: src_ip, dst_ip, sport, dport, seq_number, ack_number, time_ns
    input  wire logic [223:0] i_s_tdata,
    // tuser: bypass
    input  wire logic         i_s_tuser,
    // verdict master side
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // tdata: cookie_age, hash_value
    output logic [63:0]       o_m_tdata,
    // tuser: accept
    output logic              o_m_tuser
);

    // ------------------------------------------------------------------
    // Config regs. The user writes only while the pipeline is empty; unchecked.
    // ------------------------------------------------------------------
    logic [31:0] r_key_low;
    logic [31:0] r_key_high;
    logic [4:0]  r_period_shift;
    logic [7:0]  r_max_age;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low      <= KEY_LOW_RST;
            r_key_high     <= KEY_HIGH_RST;
            r_period_shift <= PERIOD_SHIFT_RST;
            r_max_age      <= MAX_AGE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_KEY_LOW:      r_key_low      <= i_cfg_data;
                REG_KEY_HIGH:     r_key_high     <= i_cfg_data;
                REG_PERIOD_SHIFT: r_period_shift <= i_cfg_data[4:0];
                REG_MAX_AGE:      r_max_age      <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control. A stage may load when it is empty or when the stage
    // after it moves on in the same cycle.
    // ------------------------------------------------------------------
    logic [IDX_OUT:0]   r_vld;
    logic [IDX_OUT+1:0] w_rdy;

    assign w_rdy[IDX_OUT+1] = i_m_tready;

    generate
        for (genvar k = 0; k <= IDX_OUT; k++) begin : g_rdy
            assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k <= IDX_OUT; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_s_tready = w_rdy[0];

    // ------------------------------------------------------------------
    // Stage 0: unpack, key the initial state, fold the first message word
    // into v3, and form count - (ack - 1) from the time stamp.
    // ------------------------------------------------------------------
    t_hstage r_hs [0:NUM_HALF];
    t_hstage n_hs [0:NUM_HALF];

    logic [31:0] w_src_ip;
    logic [31:0] w_dst_ip;
    logic [15:0] w_sport;
    logic [15:0] w_dport;
    logic [31:0] w_seq;
    logic [31:0] w_ack;
    logic [63:0] w_time;
    logic [31:0] w_count;

    assign w_src_ip = i_s_tdata[31:0];
    assign w_dst_ip = i_s_tdata[63:32];
    assign w_sport  = i_s_tdata[79:64];
    assign w_dport  = i_s_tdata[95:80];
    assign w_seq    = i_s_tdata[127:96];
    assign w_ack    = i_s_tdata[159:128];
    assign w_time   = i_s_tdata[223:160];

    // time in 65536 ns units, then one count per cookie period
    assign w_count = w_time[47:16] >> r_period_shift;

    always_comb begin
        n_hs[0].m[0]   = w_src_ip;
        n_hs[0].m[1]   = w_dst_ip;
        n_hs[0].m[2]   = {w_sport, w_dport};
        n_hs[0].m[3]   = w_seq;
        n_hs[0].v[0]   = IV0 ^ r_key_low;
        n_hs[0].v[1]   = IV1 ^ r_key_high;
        n_hs[0].v[2]   = IV2 ^ r_key_low;
        n_hs[0].v[3]   = IV3 ^ r_key_high ^ w_src_ip;
        n_hs[0].part   = w_count - (w_ack - 32'd1);
        n_hs[0].bypass = i_s_tuser;
    end

    // ------------------------------------------------------------------
    // Stages 1..24: one half round each. At the end of every second round
    // of the absorb phase, finish the current word in v0 and start the next
    // one in v3; after the last word flip the low byte of v2 instead.
    // ------------------------------------------------------------------
    generate
        for (genvar g = 1; g <= NUM_HALF; g++) begin : g_half
            localparam int  H      = g - 1;
            localparam int  R      = H / 2;
            localparam bit  IS_B   = (H % 2) == 1;
            localparam bit  ENDABS = IS_B && ((R % 2) == 1) && (R < 8);
            localparam int  W      = (R / 2) % 4;
            localparam int  WN     = (W < 3) ? W + 1 : 0;
            localparam bit  LASTW  = (W == 3);

            always_comb begin
                n_hs[g] = r_hs[g-1];
                if (IS_B) begin
                    n_hs[g].v = half_b(r_hs[g-1].v);
                end else begin
                    n_hs[g].v = half_a(r_hs[g-1].v);
                end
                if (ENDABS) begin
                    n_hs[g].v[0] = n_hs[g].v[0] ^ r_hs[g-1].m[W];
                    if (LASTW) begin
                        n_hs[g].v[2] = n_hs[g].v[2] ^ FINAL_XOR;
                    end else begin
                        n_hs[g].v[3] = n_hs[g].v[3] ^ r_hs[g-1].m[WN];
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        for (int k = 0; k <= NUM_HALF; k++) begin
            if (w_rdy[k]) begin
                r_hs[k] <= n_hs[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 25: collapse the state into the hash and finish the age.
    // ------------------------------------------------------------------
    logic [31:0] r_fin_hash;
    logic [31:0] r_fin_age;
    logic        r_fin_bypass;
    logic [31:0] n_fin_hash;

    assign n_fin_hash = r_hs[NUM_HALF].v[0] ^ r_hs[NUM_HALF].v[1]
                      ^ r_hs[NUM_HALF].v[2] ^ r_hs[NUM_HALF].v[3];

    always_ff @(posedge i_clk) begin
        if (w_rdy[IDX_FIN]) begin
            r_fin_hash   <= n_fin_hash;
            r_fin_age    <= r_hs[NUM_HALF].part - n_fin_hash;
            r_fin_bypass <= r_hs[NUM_HALF].bypass;
        end
    end

    // ------------------------------------------------------------------
    // Stage 26: verdict and output register. Hold while the sink stalls.
    // ------------------------------------------------------------------
    logic [31:0] r_out_hash;
    logic [31:0] r_out_age;
    logic        r_out_accept;

    always_ff @(posedge i_clk) begin
        if (w_rdy[IDX_OUT]) begin
            r_out_hash   <= r_fin_hash;
            r_out_age    <= r_fin_age;
            r_out_accept <= r_fin_bypass || (r_fin_age < {24'd0, r_max_age});
        end
    end

    assign o_m_tvalid = r_vld[IDX_OUT];
    assign o_m_tdata  = {r_out_hash, r_out_age};
    assign o_m_tuser  = r_out_accept;

`ifndef SYNTHESIS
    // the input side stalls only when a result is waiting and not taken
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("input stalled without output backpressure");

    // the finish stage keeps its packet while the output stage is held
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[IDX_FIN] && !w_rdy[IDX_OUT]) |=> r_vld[IDX_FIN])
        else $error("finish stage lost a packet during a stall");

    // the pipeline is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (r_vld == '0))
        else $error("valid bits not cleared by reset");

    // a new result on the output was in the finish stage in the cycle before
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_m_tvalid)) |-> $past(r_vld[IDX_FIN]))
        else $error("output valid without a packet in the finish stage");
`endif

endmodule

`default_nettype wire
